>>> src/qxm_pkg.sv
// ----------------------------------------------------------------------------
// qxm_pkg: shared types and constants of the X-quad mixer
// Field widths, fixed-point constants, microcode word layout, status codes.
// ----------------------------------------------------------------------------
package qxm_pkg;

  localparam int MaxResBits  = 14;
  localparam int InFracBits  = 14;
  localparam int DutyW       = MaxResBits;
  localparam int ResW        = 4;
  localparam int NumMotors   = 4;
  localparam int MotorW      = $clog2(NumMotors);
  localparam int OpW         = 3;
  localparam int IdxW        = 3;
  localparam int CmdW        = 18;
  localparam int PctW        = 8;
  localparam int PctSatW     = 7;
  localparam int ComboW      = CmdW + 2;
  localparam int ValW        = InFracBits + 1;
  localparam int MixScale    = 4428;
  localparam int ScaleShift  = 16;
  localparam int PctMax      = 100;
  localparam int RecipShift  = 27;
  localparam int PctRecip    = 1342178;    // ceil(2^27 / 100)
  localparam int PctProdW    = 21;
  localparam int MulW        = 22;
  localparam int ProdW       = 2 * MulW;
  localparam int UpcW        = 4;
  localparam int ApbAddrW    = 3;
  localparam int ApbDataW    = 32;

  localparam logic signed [ComboW-1:0] OneVal = ComboW'(1 << InFracBits);

  typedef logic [UpcW-1:0]   upc_t;
  typedef logic [DutyW-1:0]  duty_t;

  typedef enum logic [OpW-1:0] {
    OP_MIX    = 3'd0,
    OP_SET    = 3'd1,
    OP_TEST   = 3'd2,
    OP_ARM    = 3'd3,
    OP_DISARM = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_IGNORED   = 2'd2
  } status_e;

  // register indexes on the APB port
  localparam logic REG_DRIVER_READY = 1'b0;
  localparam logic REG_RES_BITS     = 1'b1;

  // multiplier operand selects
  typedef enum logic [2:0] {
    A_COMBO  = 3'd0,
    A_MIXSUM = 3'd1,
    A_VALUE  = 3'd2,
    A_PCT    = 3'd3,
    A_PROD   = 3'd4
  } a_sel_e;

  typedef enum logic [1:0] {
    B_SCALE   = 2'd0,
    B_MAXDUTY = 2'd1,
    B_RECIP   = 2'd2
  } b_sel_e;

  typedef enum logic [2:0] {
    WR_NONE    = 3'd0,
    WR_MIX     = 3'd1,
    WR_IDX_Q   = 3'd2,
    WR_IDX_PCT = 3'd3,
    WR_CLEAR   = 3'd4
  } wr_sel_e;

  typedef enum logic [1:0] {
    ARM_KEEP = 2'd0,
    ARM_SET  = 2'd1,
    ARM_CLR  = 2'd2
  } arm_e;

  typedef enum logic [1:0] {
    J_NEXT   = 2'd0,
    J_ALWAYS = 2'd1,
    J_LOOP   = 2'd2,
    J_FINISH = 2'd3
  } jump_e;

  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    logic    mul_en;
    wr_sel_e wr;
    arm_e    arm;
    logic    cnt_inc;
    jump_e   jump;
    upc_t    target;
  } ucode_t;

  typedef struct packed {
    ucode_t              uc;
    logic [MotorW-1:0]   motor;
    logic                load_out;
  } seq_ctl_t;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic signed [CmdW-1:0] thrust;
    logic signed [CmdW-1:0] roll_cmd;
    logic signed [CmdW-1:0] pitch_cmd;
    logic signed [CmdW-1:0] yaw_cmd;
    logic [IdxW-1:0]        motor_index;
    logic signed [CmdW-1:0] motor_value;
    logic [PctW-1:0]        test_pct;
  } in_word_t;

  typedef struct packed {
    duty_t [NumMotors-1:0]  duty;
    logic [NumMotors-1:0]   changed_mask;
    logic                   is_armed;
    logic [1:0]             status;
  } out_word_t;

  // microcode entry points
  localparam upc_t UA_MIX_COMBO = 4'd0;
  localparam upc_t UA_MIX_SCALE = 4'd1;
  localparam upc_t UA_MIX_WRITE = 4'd2;
  localparam upc_t UA_FINISH    = 4'd3;
  localparam upc_t UA_SET_MUL   = 4'd4;
  localparam upc_t UA_SET_WRITE = 4'd5;
  localparam upc_t UA_TEST_MUL  = 4'd6;
  localparam upc_t UA_TEST_DIV  = 4'd7;
  localparam upc_t UA_TEST_WR   = 4'd8;
  localparam upc_t UA_DISARM    = 4'd9;
  localparam upc_t UA_ARM       = 4'd10;

  function automatic ucode_t mk_uc(a_sel_e a, b_sel_e b, logic mul, wr_sel_e w,
                                   arm_e ar, logic inc, jump_e j, upc_t t);
    ucode_t u;
    u.a_sel   = a;
    u.b_sel   = b;
    u.mul_en  = mul;
    u.wr      = w;
    u.arm     = ar;
    u.cnt_inc = inc;
    u.jump    = j;
    u.target  = t;
    return u;
  endfunction

  localparam ucode_t UcNop = '{a_sel: A_COMBO, b_sel: B_SCALE, mul_en: 1'b0,
                               wr: WR_NONE, arm: ARM_KEEP, cnt_inc: 1'b0,
                               jump: J_FINISH, target: UA_FINISH};

  function automatic logic signed [ComboW-1:0] sx(logic signed [CmdW-1:0] v);
    return {{(ComboW-CmdW){v[CmdW-1]}}, v};
  endfunction

  // roll/pitch/yaw sign pattern of the X layout: FR, RR, RL, FL
  function automatic logic signed [ComboW-1:0] combo(logic [MotorW-1:0] m,
      logic signed [CmdW-1:0] r, logic signed [CmdW-1:0] p,
      logic signed [CmdW-1:0] y);
    logic signed [ComboW-1:0] rr, pp, yy, res;
    rr = sx(r);
    pp = sx(p);
    yy = sx(y);
    case (m)
      2'd0:    res = -rr + pp + yy;
      2'd1:    res = -rr - pp - yy;
      2'd2:    res =  rr - pp + yy;
      default: res =  rr + pp - yy;
    endcase
    return res;
  endfunction

  // clamp to [0, 1.0]
  function automatic logic [ValW-1:0] clamp_unit(logic signed [ComboW-1:0] v);
    logic [ValW-1:0] res;
    if (v < 0) res = '0;
    else if (v > OneVal) res = OneVal[ValW-1:0];
    else res = v[ValW-1:0];
    return res;
  endfunction

endpackage

>>> src/qxm_if.sv
// ----------------------------------------------------------------------------
// qxm_in_if / qxm_out_if: valid/ready channels of the mixer
// Command words in, duty report words out.
// ----------------------------------------------------------------------------
interface qxm_in_if import qxm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic signed [CmdW-1:0] thrust;
  logic signed [CmdW-1:0] roll_cmd;
  logic signed [CmdW-1:0] pitch_cmd;
  logic signed [CmdW-1:0] yaw_cmd;
  logic [IdxW-1:0]        motor_index;
  logic signed [CmdW-1:0] motor_value;
  logic [PctW-1:0]        test_pct;

  modport source (output valid, op, thrust, roll_cmd, pitch_cmd, yaw_cmd, motor_index,
                  motor_value, test_pct, input ready);
  modport sink (input valid, op, thrust, roll_cmd, pitch_cmd, yaw_cmd, motor_index,
                motor_value, test_pct, output ready);
endinterface

interface qxm_out_if import qxm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DutyW-1:0]     duty_front_right;
  logic [DutyW-1:0]     duty_rear_right;
  logic [DutyW-1:0]     duty_rear_left;
  logic [DutyW-1:0]     duty_front_left;
  logic [NumMotors-1:0] changed_mask;
  logic                 is_armed;
  logic [1:0]           status;

  modport source (output valid, duty_front_right, duty_rear_right, duty_rear_left,
                  duty_front_left, changed_mask, is_armed, status, input ready);
  modport sink (input valid, duty_front_right, duty_rear_right, duty_rear_left,
                duty_front_left, changed_mask, is_armed, status, output ready);
endinterface

>>> src/qxm_rom.sv
// ----------------------------------------------------------------------------
// qxm_rom: microcode store
// One control word per step; mix loops three steps per motor.
// ----------------------------------------------------------------------------
module qxm_rom import qxm_pkg::*; (
  input  upc_t   upc_i,
  output ucode_t word_o
);

  always_comb begin
    case (upc_i)
      UA_MIX_COMBO: word_o = mk_uc(A_COMBO, B_SCALE, 1'b1, WR_NONE, ARM_KEEP, 1'b0,
                                   J_NEXT, UA_FINISH);
      UA_MIX_SCALE: word_o = mk_uc(A_MIXSUM, B_MAXDUTY, 1'b1, WR_NONE, ARM_KEEP, 1'b0,
                                   J_NEXT, UA_FINISH);
      UA_MIX_WRITE: word_o = mk_uc(A_COMBO, B_SCALE, 1'b0, WR_MIX, ARM_KEEP, 1'b1,
                                   J_LOOP, UA_MIX_COMBO);
      UA_FINISH:    word_o = UcNop;
      UA_SET_MUL:   word_o = mk_uc(A_VALUE, B_MAXDUTY, 1'b1, WR_NONE, ARM_KEEP, 1'b0,
                                   J_NEXT, UA_FINISH);
      UA_SET_WRITE: word_o = mk_uc(A_COMBO, B_SCALE, 1'b0, WR_IDX_Q, ARM_KEEP, 1'b0,
                                   J_ALWAYS, UA_FINISH);
      UA_TEST_MUL:  word_o = mk_uc(A_PCT, B_MAXDUTY, 1'b1, WR_NONE, ARM_KEEP, 1'b0,
                                   J_NEXT, UA_FINISH);
      // divide by 100 through the reciprocal
      UA_TEST_DIV:  word_o = mk_uc(A_PROD, B_RECIP, 1'b1, WR_NONE, ARM_KEEP, 1'b0,
                                   J_NEXT, UA_FINISH);
      UA_TEST_WR:   word_o = mk_uc(A_COMBO, B_SCALE, 1'b0, WR_IDX_PCT, ARM_KEEP, 1'b0,
                                   J_ALWAYS, UA_FINISH);
      UA_DISARM:    word_o = mk_uc(A_COMBO, B_SCALE, 1'b0, WR_CLEAR, ARM_CLR, 1'b0,
                                   J_ALWAYS, UA_FINISH);
      UA_ARM:       word_o = mk_uc(A_COMBO, B_SCALE, 1'b0, WR_NONE, ARM_SET, 1'b0,
                                   J_ALWAYS, UA_FINISH);
      default:      word_o = UcNop;
    endcase
  end

endmodule

>>> src/qxm_seq.sv
// ----------------------------------------------------------------------------
// qxm_seq: microcode sequencer
// Step counter, motor loop counter, jumps and the output valid flag.
// ----------------------------------------------------------------------------
module qxm_seq import qxm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  upc_t     entry_i,
  input  logic     out_ready_i,
  output logic     busy_o,
  output logic     out_valid_o,
  output seq_ctl_t ctl_o
);

  localparam logic [MotorW-1:0] MotorLast = MotorW'(NumMotors - 1);

  upc_t              upc_q, upc_d;
  logic [MotorW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              out_valid_q, out_valid_d;
  ucode_t            rom_word, uc;
  logic              fire_out;

  qxm_rom u_rom (
    .upc_i  (upc_q),
    .word_o (rom_word)
  );

  assign uc = busy_q ? rom_word : UcNop;
  // finish step waits for the output register to be free
  assign fire_out = busy_q && (uc.jump == J_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    upc_d  = upc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
      upc_d  = entry_i;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (uc.cnt_inc) cnt_d = cnt_q + 1'b1;
      case (uc.jump)
        J_NEXT:   upc_d = upc_q + 1'b1;
        J_ALWAYS: upc_d = uc.target;
        J_LOOP:   upc_d = (cnt_q != MotorLast) ? uc.target : upc_t'(upc_q + 1'b1);
        J_FINISH: if (fire_out) busy_d = 1'b0;
        default:  upc_d = upc_q;
      endcase
    end
  end

  always_comb begin
    if (fire_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UA_FINISH;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign busy_o         = busy_q;
  assign out_valid_o    = out_valid_q;
  assign ctl_o.uc       = uc;
  assign ctl_o.motor    = cnt_q;
  assign ctl_o.load_out = fire_out;

endmodule

>>> src/qxm_cfg.sv
// ----------------------------------------------------------------------------
// qxm_cfg: APB register file
// driver_ready at 0x0, duty_resolution_bits at 0x4.
// ----------------------------------------------------------------------------
module qxm_cfg import qxm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic                drv_ready_o,
  output logic [ResW-1:0]     res_bits_o
);

  logic            drv_ready_q;
  logic [ResW-1:0] res_bits_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_ready_q <= 1'b0;
      res_bits_q  <= ResW'(8);
    end else if (wr_en) begin
      case (paddr[2])
        REG_DRIVER_READY: drv_ready_q <= pwdata[0];
        REG_RES_BITS:     res_bits_q  <= pwdata[ResW-1:0];
        default:          drv_ready_q <= drv_ready_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DRIVER_READY: prdata = ApbDataW'(drv_ready_q);
      REG_RES_BITS:     prdata = ApbDataW'(res_bits_q);
      default:          prdata = '0;
    endcase
  end

  assign drv_ready_o = drv_ready_q;
  assign res_bits_o  = res_bits_q;

endmodule

>>> src/qxm_datapath.sv
// ----------------------------------------------------------------------------
// qxm_datapath: command decode, shared multiplier and duty registers
// One 22x22 multiplier serves the mix scale, the duty scale and the /100.
// ----------------------------------------------------------------------------
module qxm_datapath import qxm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  in_word_t        in_i,
  input  logic            drv_ready_i,
  input  logic [ResW-1:0] res_bits_i,
  input  seq_ctl_t        ctl_i,
  output upc_t            entry_o,
  output out_word_t       out_o
);

  // captured item
  logic signed [CmdW-1:0] thrust_q, roll_q, pitch_q, yaw_q, value_q;
  logic [PctSatW-1:0]     pct_q;
  logic [MotorW-1:0]      idx_q;
  logic [1:0]             status_q;
  logic [NumMotors-1:0]   mask_q;

  // state
  logic                   armed_q;
  duty_t [NumMotors-1:0]  duty_q;

  logic signed [ProdW-1:0] prod_q;
  out_word_t               out_q;

  // decode
  status_e              dec_status;
  logic [NumMotors-1:0] dec_mask;
  upc_t                 dec_entry;
  logic [NumMotors-1:0] idx_bit;

  assign idx_bit = NumMotors'(1) << in_i.motor_index[MotorW-1:0];

  always_comb begin
    dec_status = ST_DONE;
    dec_mask   = '0;
    dec_entry  = UA_FINISH;
    case (in_i.op)
      OP_MIX, OP_SET, OP_TEST, OP_ARM, OP_DISARM: begin
        if (!drv_ready_i) begin
          dec_status = ST_NOT_READY;
        end else begin
          case (in_i.op)
            OP_MIX: begin
              if (!armed_q) dec_status = ST_IGNORED;
              else begin
                dec_entry = UA_MIX_COMBO;
                dec_mask  = '1;
              end
            end
            OP_SET: begin
              if (!armed_q || in_i.motor_index[IdxW-1]) dec_status = ST_IGNORED;
              else begin
                dec_entry = UA_SET_MUL;
                dec_mask  = idx_bit;
              end
            end
            OP_TEST: begin
              if (in_i.motor_index[IdxW-1]) dec_status = ST_IGNORED;
              else begin
                dec_entry = UA_TEST_MUL;
                dec_mask  = idx_bit;
              end
            end
            OP_ARM: dec_entry = UA_ARM;
            default: begin
              dec_entry = UA_DISARM;
              dec_mask  = '1;
            end
          endcase
        end
      end
      default: dec_status = ST_IGNORED;
    endcase
  end

  assign entry_o = dec_entry;

  // max duty = 2^res - 1 with res held to 1..MaxResBits
  logic [ResW-1:0]  res_eff;
  logic [DutyW:0]   res_pow;
  duty_t            duty_full;

  always_comb begin
    res_eff = res_bits_i;
    if (res_bits_i == '0) res_eff = ResW'(1);
    else if (res_bits_i > ResW'(MaxResBits)) res_eff = ResW'(MaxResBits);
  end

  assign res_pow   = (DutyW+1)'(1) << res_eff;
  assign duty_full = DutyW'(res_pow - 1'b1);

  // multiplier operands
  logic signed [ComboW-1:0] mix_sum;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  prod_d;

  assign mix_sum = sx(thrust_q) + $signed(prod_q[ScaleShift+ComboW-1:ScaleShift]);

  always_comb begin
    case (ctl_i.uc.a_sel)
      A_COMBO:  mul_a = MulW'(combo(ctl_i.motor, roll_q, pitch_q, yaw_q));
      A_MIXSUM: mul_a = $signed(MulW'(clamp_unit(mix_sum)));
      A_VALUE:  mul_a = $signed(MulW'(clamp_unit(sx(value_q))));
      A_PCT:    mul_a = $signed(MulW'(pct_q));
      A_PROD:   mul_a = $signed(MulW'(prod_q[PctProdW-1:0]));
      default:  mul_a = '0;
    endcase
    case (ctl_i.uc.b_sel)
      B_SCALE:   mul_b = MulW'(MixScale);
      B_MAXDUTY: mul_b = $signed(MulW'(duty_full));
      B_RECIP:   mul_b = MulW'(PctRecip);
      default:   mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      thrust_q <= in_i.thrust;
      roll_q   <= in_i.roll_cmd;
      pitch_q  <= in_i.pitch_cmd;
      yaw_q    <= in_i.yaw_cmd;
      value_q  <= in_i.motor_value;
      pct_q    <= (in_i.test_pct > PctW'(PctMax)) ? PctSatW'(PctMax)
                                                  : in_i.test_pct[PctSatW-1:0];
      idx_q    <= in_i.motor_index[MotorW-1:0];
      status_q <= dec_status;
      mask_q   <= dec_mask;
    end
    if (ctl_i.uc.mul_en) prod_q <= prod_d;
    if (ctl_i.load_out) begin
      out_q.duty         <= duty_q;
      out_q.changed_mask <= mask_q;
      out_q.is_armed     <= armed_q;
      out_q.status       <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      duty_q  <= '0;
    end else begin
      case (ctl_i.uc.arm)
        ARM_SET: armed_q <= 1'b1;
        ARM_CLR: armed_q <= 1'b0;
        default: armed_q <= armed_q;
      endcase
      case (ctl_i.uc.wr)
        WR_MIX:     duty_q[ctl_i.motor] <= prod_q[InFracBits+DutyW-1:InFracBits];
        WR_IDX_Q:   duty_q[idx_q]       <= prod_q[InFracBits+DutyW-1:InFracBits];
        WR_IDX_PCT: duty_q[idx_q]       <= prod_q[RecipShift+DutyW-1:RecipShift];
        WR_CLEAR:   duty_q              <= '0;
        default:    duty_q              <= duty_q;
      endcase
    end
  end

  assign out_o = out_q;

endmodule

>>> src/quad_x_mixer_pwm_duty.sv
// ----------------------------------------------------------------------------
// quad_x_mixer_pwm_duty: X-quad motor mixer with arm gating and PWM duties
// Microcoded: a short control program drives one shared multiplier.
// ----------------------------------------------------------------------------
//  port      dir  handshake       word
//  in_i      in   valid/ready     op, thrust, roll/pitch/yaw, index, value, pct
//  out_o     out  valid/ready     four duties, changed_mask, is_armed, status
//  APB       in   psel/penable    driver_ready @0x0, duty_resolution_bits @0x4
//
// One word at a time. Mix: combo, scale and write per motor (three microcode
// steps per motor on the multiplier); set motor: multiply, write; test motor:
// multiply, divide, write; arm or disarm: update; rejected words: finish only.
// The output register frees the input side: a new word is taken while a
// report waits; the finish step stalls only if the previous report is unread.
// Reset: disarmed, all duties zero, driver not ready, resolution 8 bits.
// ----------------------------------------------------------------------------
module quad_x_mixer_pwm_duty import qxm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  qxm_in_if.sink              in_i,
  qxm_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic            drv_ready;
  logic [ResW-1:0] res_bits;
  logic            busy;
  logic            start;
  upc_t            entry;
  seq_ctl_t        ctl;
  in_word_t        in_w;
  out_word_t       out_w;

  assign in_i.ready = !busy;
  assign start      = in_i.valid && !busy;

  assign in_w.op          = in_i.op;
  assign in_w.thrust      = in_i.thrust;
  assign in_w.roll_cmd    = in_i.roll_cmd;
  assign in_w.pitch_cmd   = in_i.pitch_cmd;
  assign in_w.yaw_cmd     = in_i.yaw_cmd;
  assign in_w.motor_index = in_i.motor_index;
  assign in_w.motor_value = in_i.motor_value;
  assign in_w.test_pct    = in_i.test_pct;

  qxm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .drv_ready_o (drv_ready),
    .res_bits_o  (res_bits)
  );

  qxm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .entry_i     (entry),
    .out_ready_i (out_o.ready),
    .busy_o      (busy),
    .out_valid_o (out_o.valid),
    .ctl_o       (ctl)
  );

  qxm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .in_i        (in_w),
    .drv_ready_i (drv_ready),
    .res_bits_i  (res_bits),
    .ctl_i       (ctl),
    .entry_o     (entry),
    .out_o       (out_w)
  );

  assign out_o.duty_front_right = out_w.duty[0];
  assign out_o.duty_rear_right  = out_w.duty[1];
  assign out_o.duty_rear_left   = out_w.duty[2];
  assign out_o.duty_front_left  = out_w.duty[3];
  assign out_o.changed_mask     = out_w.changed_mask;
  assign out_o.is_armed         = out_w.is_armed;
  assign out_o.status           = out_w.status;

endmodule

>>> src/qxm_checker.sv
// ----------------------------------------------------------------------------
// qxm_checker: port-level checks of the mixer
// Bound to the top level.
// ----------------------------------------------------------------------------
module qxm_checker import qxm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [DutyW-1:0]     duty_fr_i,
  input logic [DutyW-1:0]     duty_rr_i,
  input logic [DutyW-1:0]     duty_rl_i,
  input logic [DutyW-1:0]     duty_fl_i,
  input logic [NumMotors-1:0] changed_mask_i,
  input logic                 is_armed_i,
  input logic [1:0]           status_i
);

  // an accepted word makes the sequencer busy, so input ready is low in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(duty_fr_i) &&
      $stable(duty_rr_i) && $stable(duty_rl_i) && $stable(duty_fl_i) &&
      $stable(changed_mask_i) && $stable(is_armed_i) && $stable(status_i))
    else $error("stalled report changed");

  a_reject_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_DONE) |-> changed_mask_i == '0)
    else $error("rejected word reports rewritten duties");

  // all four rewritten while disarmed can only be a disarm
  a_disarm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (changed_mask_i == '1) && !is_armed_i |->
      duty_fr_i == '0 && duty_rr_i == '0 && duty_rl_i == '0 && duty_fl_i == '0)
    else $error("disarm left a nonzero duty");

endmodule

bind quad_x_mixer_pwm_duty qxm_checker u_qxm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .duty_fr_i      (out_o.duty_front_right),
  .duty_rr_i      (out_o.duty_rear_right),
  .duty_rl_i      (out_o.duty_rear_left),
  .duty_fl_i      (out_o.duty_front_left),
  .changed_mask_i (out_o.changed_mask),
  .is_armed_i     (out_o.is_armed),
  .status_i       (out_o.status)
);
